// ===== src/utf16_text_element_segmenter_defines.svh =====
// Assertion macros shared by the segmenter RTL.
`ifndef UTF16_TEXT_ELEMENT_SEGMENTER_DEFINES_SVH
`define UTF16_TEXT_ELEMENT_SEGMENTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif

`endif

// ===== src/u16ts_pkg.sv =====
package u16ts_pkg;

  localparam int unsigned MaxTextUnitsDefault = 65536;

  // Result queue sizing
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Code point constants
  localparam logic [15:0] LeadBase  = 16'hD800;
  localparam logic [15:0] TrailBase = 16'hDC00;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Zwj       = 21'h0200D;
  localparam logic [20:0] VsLo      = 21'h0FE00;
  localparam logic [20:0] VsHi      = 21'h0FE0F;
  localparam logic [20:0] VsSuppLo  = 21'hE0100;
  localparam logic [20:0] VsSuppHi  = 21'hE01EF;
  localparam logic [20:0] ModLo     = 21'h1F3FB;
  localparam logic [20:0] ModHi     = 21'h1F3FF;
  localparam logic [20:0] RiLo      = 21'h1F1E6;
  localparam logic [20:0] RiHi      = 21'h1F1FF;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_BASE    = 3'd1,
    PH_RI_ONE  = 3'd2,
    PH_RI_PAIR = 3'd3,
    PH_JOINER  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [20:0] code_point;
    logic [15:0] unit_offset;
    logic [1:0]  unit_count;
    logic        starts_element;
    logic        text_end;
    logic        run_last;
  } result_t;

  // Results produced by one accepted word
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             ready;
  } qstat_t;

  typedef struct packed {
    logic   held_valid;
    phase_e phase;
  } cstat_t;

  typedef struct packed {
    logic   starts;
    phase_e phase;
  } class_t;

  function automatic logic is_suffix(logic [20:0] cp);
    return (cp >= VsLo && cp <= VsHi) || (cp >= VsSuppLo && cp <= VsSuppHi) ||
           (cp >= ModLo && cp <= ModHi);
  endfunction

  function automatic logic is_regional(logic [20:0] cp);
    return cp >= RiLo && cp <= RiHi;
  endfunction

  // Boundary decision before cp, plus the phase that follows it
  function automatic class_t classify(phase_e ph, logic [20:0] cp);
    class_t res;
    res.starts = 1'b1;
    res.phase  = is_regional(cp) ? PH_RI_ONE : PH_BASE;
    case (ph)
      PH_JOINER: begin
        res = '{starts: 1'b0, phase: PH_BASE};
      end
      PH_BASE: begin
        if (is_suffix(cp)) begin
          res = '{starts: 1'b0, phase: PH_BASE};
        end else if (cp == Zwj) begin
          res = '{starts: 1'b0, phase: PH_JOINER};
        end
      end
      PH_RI_ONE: begin
        if (is_suffix(cp)) begin
          res = '{starts: 1'b0, phase: PH_RI_ONE};
        end else if (is_regional(cp)) begin
          res = '{starts: 1'b0, phase: PH_RI_PAIR};
        end else if (cp == Zwj) begin
          res = '{starts: 1'b0, phase: PH_JOINER};
        end
      end
      PH_RI_PAIR: begin
        if (is_suffix(cp)) begin
          res = '{starts: 1'b0, phase: PH_RI_PAIR};
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

endpackage

// ===== src/u16ts_core.sv =====
// Surrogate pairing, classification and offset tracking for one word per cycle while accept_i is high.
module u16ts_core
  import u16ts_pkg::*;
#(
  parameter int unsigned MAX_TEXT_UNITS = MaxTextUnitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] code_unit_i,
  input  logic        final_unit_i,
  output push_t       push_o,
  output cstat_t      stat_o
);

  localparam logic [15:0] Cap = 16'(MAX_TEXT_UNITS - 1);

  logic [15:0] held_lead_q, held_lead_d;
  logic        held_valid_q, held_valid_d;
  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;

  logic        lead, trail, consumed, emit0, emit1;
  logic [20:0] cp0, cp1;
  logic [1:0]  cnt0;
  class_t      cls0, cls1;
  phase_e      phase_mid;
  logic [15:0] pos_mid, pos_end;
  result_t     r0, r1;

  // Saturating advance of the unit position
  function automatic logic [15:0] advance(logic [15:0] pos, logic [1:0] cnt);
    logic [16:0] nxt;
    nxt = {1'b0, pos} + 17'(cnt);
    return (nxt > {1'b0, Cap}) ? Cap : nxt[15:0];
  endfunction

  // Decode
  always_comb begin
    lead     = code_unit_i[15:10] == LeadBase[15:10];
    trail    = code_unit_i[15:10] == TrailBase[15:10];
    consumed = held_valid_q && trail;
    emit0    = held_valid_q;
    emit1    = !consumed && !(lead && !final_unit_i);
    cp0      = consumed ? (SuppBase + 21'({held_lead_q[9:0], code_unit_i[9:0]}))
                        : {5'd0, held_lead_q};
    cnt0     = consumed ? 2'd2 : 2'd1;
    cp1      = {5'd0, code_unit_i};
  end

  // Classify the results in order
  always_comb begin
    cls0      = classify(phase_q, cp0);
    phase_mid = emit0 ? cls0.phase : phase_q;
    pos_mid   = emit0 ? advance(pos_q, cnt0) : pos_q;
    cls1      = classify(phase_mid, cp1);
    phase_d   = emit1 ? cls1.phase : phase_mid;
    pos_end   = emit1 ? advance(pos_mid, 2'd1) : pos_mid;

    r0.code_point     = cp0;
    r0.unit_offset    = pos_q;
    r0.unit_count     = cnt0;
    r0.starts_element = cls0.starts;
    r0.text_end       = final_unit_i && !emit1;
    r0.run_last       = !emit1;

    r1.code_point     = cp1;
    r1.unit_offset    = pos_mid;
    r1.unit_count     = 2'd1;
    r1.starts_element = cls1.starts;
    r1.text_end       = final_unit_i;
    r1.run_last       = 1'b1;

    push_o.n      = {1'b0, emit0} + {1'b0, emit1};
    push_o.first  = emit0 ? r0 : r1;
    push_o.second = r1;
  end

  // Next state; final word returns everything to reset values
  always_comb begin
    if (final_unit_i) begin
      held_valid_d = 1'b0;
      held_lead_d  = '0;
      pos_d        = '0;
    end else begin
      held_valid_d = !consumed && lead;
      held_lead_d  = (!consumed && lead) ? code_unit_i : '0;
      pos_d        = pos_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_q  <= '0;
      held_valid_q <= 1'b0;
      phase_q      <= PH_START;
      pos_q        <= '0;
    end else if (accept_i) begin
      held_lead_q  <= held_lead_d;
      held_valid_q <= held_valid_d;
      phase_q      <= final_unit_i ? PH_START : phase_d;
      pos_q        <= pos_d;
    end
  end

  assign stat_o.held_valid = held_valid_q;
  assign stat_o.phase      = phase_q;

endmodule

// ===== src/u16ts_out_queue.sv =====
// Small result queue; takes up to two results per cycle, releases at most one.
module u16ts_out_queue
  import u16ts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_en_i,
  input  push_t   push_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    valid_o,
  output qstat_t  stat_o
);

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic [1:0]       n_push;

  assign n_push = push_en_i ? push_i.n : 2'd0;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(n_push);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop_i);
    count_d  = count_q + QCntW'(n_push) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_q + QPtrW'(1)] <= push_i.second;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign valid_o      = count_q != '0;
  assign stat_o.count = count_q;
  assign stat_o.ready = count_q <= QCntW'(QDepth - 2);

endmodule

// ===== src/utf16_text_element_segmenter.sv =====
// UTF-16 text element segmenter. One code unit word is accepted per cycle while
// the input is ready; its results are registered in a four-entry result queue and
// leave it at one result per cycle while out_ready_i is high. The input is
// ready whenever the queue has room for two results, so it keeps taking words
// while earlier results wait. A lead surrogate that is not final yields no
// result of its own (it is held); a held lead followed by a word that is neither
// a trail nor a non-final lead yields two results, which leave the queue in order.
// The output is the limit: the single queue read port releases one result per cycle.
`include "utf16_text_element_segmenter_defines.svh"

module utf16_text_element_segmenter
  import u16ts_pkg::*;
#(
  parameter int unsigned MAX_TEXT_UNITS = MaxTextUnitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        final_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic [15:0] unit_offset_o,
  output logic [1:0]  unit_count_o,
  output logic        starts_element_o,
  output logic        text_end_o,
  output logic        run_last_o
);

  logic    in_acc, pop;
  push_t   push;
  cstat_t  cstat;
  qstat_t  qstat;
  result_t head;

  assign in_acc = in_valid_i && in_ready_o;
  assign pop    = out_valid_o && out_ready_i;

  u16ts_core #(
    .MAX_TEXT_UNITS(MAX_TEXT_UNITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .code_unit_i (code_unit_i),
    .final_unit_i(final_unit_i),
    .push_o      (push),
    .stat_o      (cstat)
  );

  u16ts_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(in_acc),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .valid_o  (out_valid_o),
    .stat_o   (qstat)
  );

  assign in_ready_o       = qstat.ready;
  assign code_point_o     = head.code_point;
  assign unit_offset_o    = head.unit_offset;
  assign unit_count_o     = head.unit_count;
  assign starts_element_o = head.starts_element;
  assign text_end_o       = head.text_end;
  assign run_last_o       = head.run_last;

  // Checks
  `ASSERT_IMPLIES(a_q_bound, clk_i, rst_ni, 1'b1, qstat.count <= QCntW'(QDepth), "queue overfill")
  `ASSERT_IMPLIES(a_two_needs_lead, clk_i, rst_ni, in_acc && push.n == 2'd2, cstat.held_valid,
                  "two results without a held lead")
  `ASSERT_NEXT(a_final_clears, clk_i, rst_ni, in_acc && final_unit_i,
               !cstat.held_valid && cstat.phase == PH_START, "state not cleared after final")

endmodule
